// ===== hw/rtl/clint_pkg.sv =====
package clint_pkg;

  // number of harts served; the per-hart output lines cover the first OUT_HARTS
  localparam int NUM_HARTS = 4;
  localparam int OUT_HARTS = 4;

  localparam int OP_W    = 2;
  localparam int SEL_W   = 3;
  localparam int HART_W  = 2;
  localparam int WORD_W  = 32;
  localparam int TIME_W  = 64;
  localparam int TUSER_W = OP_W + SEL_W + HART_W;
  localparam int IN_TDATA_W  = WORD_W;
  localparam int OUT_TDATA_W = WORD_W + 2 * OUT_HARTS;

  localparam logic [TIME_W-1:0] CMP_DISABLED = '1;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_SOFT    = 3'd0,
    SEL_CMP_LO  = 3'd1,
    SEL_CMP_HI  = 3'd2,
    SEL_TIME_LO = 3'd3,
    SEL_TIME_HI = 3'd4
  } sel_t;

  // one bus access or tick
  typedef struct packed {
    op_t               op;
    sel_t              sel;
    logic [HART_W-1:0] hart;
    logic [WORD_W-1:0] data;
  } item_t;

  // item handed to the register file for its update
  typedef struct packed {
    logic  valid;
    item_t item;
  } upd_t;

endpackage

// ===== hw/rtl/core_local_interruptor.sv =====
// Core-local interruptor: 64-bit time counter, a compare value and a
// software flag per hart, reached through a stream of register accesses.
// Input channel (in_*): one transfer is a 32-bit read or write of one
// register half, or a single time tick; the operation, register select and
// hart travel in in_tuser, the write data in in_tdata.
// Output channel (out_*): exactly one transfer per input transfer, in order,
// carrying read data (zero for writes and ticks) and the software and timer
// interrupt lines as they stand right after that item took effect.
// An accepted item passes the input register, the register file update stage
// and the output register before it shows on out_tvalid. Throughput: one item
// every cycle while the receiver does not stall, set by the three-register
// pipe (input register, register file update, output register), all
// advancing together on one enable. When the receiver stalls, the whole pipe
// holds and in_tready drops; the state is only updated as an item moves out
// of the input register. Reset clears the pipe, time to zero, soft flags to
// zero and every compare value to all ones, which keeps the timer lines low.
module core_local_interruptor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [clint_pkg::IN_TDATA_W-1:0]      in_tdata,   // write_data
  input  logic [clint_pkg::TUSER_W-1:0]         in_tuser,   // op, reg_select, hart
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [clint_pkg::OUT_TDATA_W-1:0]     out_tdata   // read_data, software_irq, timer_irq
);
  import clint_pkg::*;

  logic              adv;
  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              s2_valid_r;
  logic [WORD_W-1:0] s2_rdata_r;
  logic              s2_is_read_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_rdata_r;
  logic [OUT_HARTS-1:0] out_sw_r;
  logic [OUT_HARTS-1:0] out_tm_r;
  logic              out_is_read_r;
  item_t             in_item;
  upd_t              upd;
  logic [WORD_W-1:0] rd_data;
  logic [OUT_HARTS-1:0] sw_irq;
  logic [OUT_HARTS-1:0] tm_irq;

  // whole pipe moves when the output is free or being taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // unpack the input transfer
  assign in_item.op   = op_t'(in_tuser[OP_W-1:0]);
  assign in_item.sel  = sel_t'(in_tuser[OP_W +: SEL_W]);
  assign in_item.hart = in_tuser[OP_W+SEL_W +: HART_W];
  assign in_item.data = in_tdata[WORD_W-1:0];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) s1_item_r <= in_item;
  end

  assign upd.valid = s1_valid_r && adv;
  assign upd.item  = s1_item_r;

  clint_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .rd_data (rd_data),
    .sw_irq  (sw_irq),
    .tm_irq  (tm_irq)
  );

  // read data captured with the state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rdata_r   <= rd_data;
      s2_is_read_r <= (s1_item_r.op == OP_READ);
    end
  end

  // output register, interrupt lines sampled after the item's update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_rdata_r   <= s2_rdata_r;
      out_sw_r      <= sw_irq;
      out_tm_r      <= tm_irq;
      out_is_read_r <= s2_is_read_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_tm_r, out_sw_r, out_rdata_r};

  // writes and ticks return zero read data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_is_read_r |-> out_rdata_r == '0)
    else $error("nonzero read data on write or tick");

  // an accepted item reaches the input register
  a_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted item dropped");

  // stage two moves into the output register on advance
  a_s2_move: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && adv |=> out_valid_r && out_rdata_r == $past(s2_rdata_r))
    else $error("result lost between stages");

endmodule

// ===== hw/rtl/clint_regfile.sv =====
module clint_regfile (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  clint_pkg::upd_t                      upd,
  output logic [clint_pkg::WORD_W-1:0]         rd_data,
  output logic [clint_pkg::OUT_HARTS-1:0]      sw_irq,
  output logic [clint_pkg::OUT_HARTS-1:0]      tm_irq
);
  import clint_pkg::*;

  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] cmp_r  [NUM_HARTS];
  logic              soft_r [NUM_HARTS];
  logic [NUM_HARTS-1:0] hsel;
  logic [NUM_HARTS-1:0] rd_soft_bits;
  logic [TIME_W-1:0]    rd_cmp_terms [NUM_HARTS];
  logic                 rd_soft;
  logic [TIME_W-1:0]    rd_cmp;
  logic                 is_wr;

  assign is_wr = upd.valid && (upd.item.op == OP_WRITE);

  // per-hart decode, registers and read terms
  for (genvar h = 0; h < NUM_HARTS; h++) begin : g_hart
    assign hsel[h] = (32'(upd.item.hart) == h);
    assign rd_soft_bits[h] = hsel[h] & soft_r[h];
    assign rd_cmp_terms[h] = hsel[h] ? cmp_r[h] : '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        soft_r[h] <= 1'b0;
        cmp_r[h]  <= CMP_DISABLED;
      end else if (is_wr && hsel[h]) begin
        if (upd.item.sel == SEL_SOFT) soft_r[h] <= upd.item.data[0];
        if (upd.item.sel == SEL_CMP_LO) cmp_r[h][WORD_W-1:0] <= upd.item.data;
        if (upd.item.sel == SEL_CMP_HI) cmp_r[h][TIME_W-1:WORD_W] <= upd.item.data;
      end
    end
  end

  // time counter: tick or half-word write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (upd.valid && upd.item.op == OP_TICK) begin
      time_r <= time_r + TIME_W'(1);
    end else if (is_wr && upd.item.sel == SEL_TIME_LO) begin
      time_r[WORD_W-1:0] <= upd.item.data;
    end else if (is_wr && upd.item.sel == SEL_TIME_HI) begin
      time_r[TIME_W-1:WORD_W] <= upd.item.data;
    end
  end

  // collapse the per-hart read terms
  always_comb begin
    rd_cmp = '0;
    for (int h = 0; h < NUM_HARTS; h++) begin
      rd_cmp = rd_cmp | rd_cmp_terms[h];
    end
  end
  assign rd_soft = |rd_soft_bits;

  // read mux, zero for anything but a read
  always_comb begin
    rd_data = '0;
    if (upd.item.op == OP_READ) begin
      unique case (upd.item.sel)
        SEL_SOFT:    rd_data = {{(WORD_W-1){1'b0}}, rd_soft};
        SEL_CMP_LO:  rd_data = rd_cmp[WORD_W-1:0];
        SEL_CMP_HI:  rd_data = rd_cmp[TIME_W-1:WORD_W];
        SEL_TIME_LO: rd_data = time_r[WORD_W-1:0];
        SEL_TIME_HI: rd_data = time_r[TIME_W-1:WORD_W];
        default:     rd_data = '0;
      endcase
    end
  end

  // interrupt lines from the current state
  for (genvar i = 0; i < OUT_HARTS; i++) begin : g_irq
    if (i < NUM_HARTS) begin : g_on
      assign sw_irq[i] = soft_r[i];
      assign tm_irq[i] = (cmp_r[i] != CMP_DISABLED) && (time_r >= cmp_r[i]);
    end else begin : g_off
      assign sw_irq[i] = 1'b0;
      assign tm_irq[i] = 1'b0;
    end
  end

  // a tick advances time by one
  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    upd.valid && upd.item.op == OP_TICK |=> time_r == $past(time_r) + TIME_W'(1))
    else $error("time did not advance on tick");

  // low time write lands and keeps the high half
  a_time_lo_wr: assert property (@(posedge clk) disable iff (!rst_n)
    is_wr && upd.item.sel == SEL_TIME_LO
    |=> time_r[WORD_W-1:0] == $past(upd.item.data)
        && time_r[TIME_W-1:WORD_W] == $past(time_r[TIME_W-1:WORD_W]))
    else $error("time low write lost");

  // hart 0 compare low write lands
  a_cmp0_wr: assert property (@(posedge clk) disable iff (!rst_n)
    is_wr && upd.item.sel == SEL_CMP_LO && upd.item.hart == '0
    |=> cmp_r[0][WORD_W-1:0] == $past(upd.item.data))
    else $error("compare write lost");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import clint_pkg::*;

  localparam logic [OP_W-1:0]  OP_NONE   = 2'd3;   // unused operation code
  localparam logic [SEL_W-1:0] SEL_LAST  = 3'd7;   // highest selector code
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic [WORD_W-1:0]    rd;
    logic [OUT_HARTS-1:0] sw;
    logic [OUT_HARTS-1:0] tm;
  } clint_view_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // write_data
  logic [TUSER_W-1:0]     in_tuser;    // op, reg_select, hart
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // read_data, software_irq, timer_irq

  // shadow copy of the register state
  logic [TIME_W-1:0] mtime_m;
  logic [TIME_W-1:0] mtimecmp_m [NUM_HARTS];
  logic              msip_m [NUM_HARTS];

  clint_view_t view_q [$];
  int  error_count;
  int  sent_count;
  bit  src_idle;
  bit  sink_idle;
  bit  hold_req;

  core_local_interruptor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #600000;
    $display("core_local_interruptor regression: fail");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls plus one long hold on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = idle_len(sink_idle);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    clint_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (view_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        want = view_q.pop_front();
        check_field("read_data", want.rd, out_tdata[WORD_W-1:0]);
        check_field("software_irq", WORD_W'(want.sw), WORD_W'(out_tdata[WORD_W +: OUT_HARTS]));
        check_field("timer_irq", WORD_W'(want.tm),
                    WORD_W'(out_tdata[WORD_W+OUT_HARTS +: OUT_HARTS]));
      end
    end
  end

  // apply one access to the shadow state, return the lines after it
  function automatic clint_view_t step_clint(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                                             logic [HART_W-1:0] hart,
                                             logic [WORD_W-1:0] data);
    clint_view_t v;
    bit ok;
    v = '0;
    ok = int'(hart) < NUM_HARTS;
    if (op == OP_READ) begin
      case (sel)
        SEL_SOFT:    if (ok) v.rd = WORD_W'(msip_m[hart]);
        SEL_CMP_LO:  if (ok) v.rd = mtimecmp_m[hart][WORD_W-1:0];
        SEL_CMP_HI:  if (ok) v.rd = mtimecmp_m[hart][TIME_W-1:WORD_W];
        SEL_TIME_LO: v.rd = mtime_m[WORD_W-1:0];
        SEL_TIME_HI: v.rd = mtime_m[TIME_W-1:WORD_W];
        default:     v.rd = '0;
      endcase
    end else if (op == OP_WRITE) begin
      case (sel)
        SEL_SOFT:    if (ok) msip_m[hart] = data[0];
        SEL_CMP_LO:  if (ok) mtimecmp_m[hart][WORD_W-1:0] = data;
        SEL_CMP_HI:  if (ok) mtimecmp_m[hart][TIME_W-1:WORD_W] = data;
        SEL_TIME_LO: mtime_m[WORD_W-1:0] = data;
        SEL_TIME_HI: mtime_m[TIME_W-1:WORD_W] = data;
        default: ;
      endcase
    end else if (op == OP_TICK) begin
      mtime_m = mtime_m + 64'd1;
    end
    for (int i = 0; i < NUM_HARTS && i < OUT_HARTS; i++) begin
      v.sw[i] = msip_m[i];
      v.tm[i] = (mtimecmp_m[i] != CMP_DISABLED) && (mtime_m >= mtimecmp_m[i]);
    end
    return v;
  endfunction

  // offer one access and wait for its transfer
  task automatic send_access(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                             input logic [HART_W-1:0] hart,
                             input logic [WORD_W-1:0] data);
    int gap;
    gap = idle_len(src_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {hart, sel, op};
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    view_q.push_back(step_clint(op, sel, hart, data));
    sent_count++;
  endtask

  // stop offering until every result is back
  task automatic drain;
    in_tvalid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_compare(input logic [HART_W-1:0] hart, input logic [TIME_W-1:0] v,
                               input bit hi_first);
    if (hi_first) send_access(OP_WRITE, SEL_CMP_HI, hart, v[TIME_W-1:WORD_W]);
    send_access(OP_WRITE, SEL_CMP_LO, hart, v[WORD_W-1:0]);
    if (!hi_first) send_access(OP_WRITE, SEL_CMP_HI, hart, v[TIME_W-1:WORD_W]);
  endtask

  // reads of every selector straight after reset
  task automatic test_reset_values;
    for (int s = 0; s <= int'(SEL_LAST); s++)
      send_access(OP_READ, SEL_W'(s), HART_W'(s), '1);
    send_access(OP_READ, SEL_CMP_HI, 2'd3, '0);
  endtask

  // only bit 0 of a soft flag write is kept
  task automatic test_soft_flags;
    send_access(OP_WRITE, SEL_SOFT, 2'd0, 32'hFFFF_FFFE);
    send_access(OP_WRITE, SEL_SOFT, 2'd3, 32'hFFFF_FFFF);
    send_access(OP_WRITE, SEL_SOFT, 2'd1, 32'h0000_0001);
    send_access(OP_READ,  SEL_SOFT, 2'd3, '0);
    send_access(OP_WRITE, SEL_SOFT, 2'd3, 32'h0000_0000);
  endtask

  // timer fires at equality, all ones disables, time wraps at 2^64
  task automatic test_timer;
    write_compare(2'd1, 64'd2, 1'b0);
    send_access(OP_TICK, SEL_SOFT, 2'd0, '0);
    send_access(OP_TICK, SEL_SOFT, 2'd0, '0);
    write_compare(2'd2, 64'd0, 1'b1);
    send_access(OP_WRITE, SEL_TIME_LO, 2'd0, 32'hFFFF_FFFF);
    send_access(OP_WRITE, SEL_TIME_HI, 2'd0, 32'hFFFF_FFFF);
    send_access(OP_READ,  SEL_TIME_HI, 2'd0, '0);
    send_access(OP_TICK,  SEL_SOFT, 2'd0, '0);
    send_access(OP_READ,  SEL_TIME_LO, 2'd0, '0);
    write_compare(2'd2, CMP_DISABLED, 1'b0);
    write_compare(2'd1, CMP_DISABLED, 1'b0);
  endtask

  // unused operation and selectors change nothing
  task automatic test_unused_codes;
    send_access(OP_NONE, SEL_TIME_LO, 2'd0, 32'hA5A5_A5A5);
    for (int s = int'(SEL_TIME_HI) + 1; s <= int'(SEL_LAST); s++)
      send_access(OP_WRITE, SEL_W'(s), 2'd1, '1);
    send_access(OP_READ, SEL_TIME_LO, 2'd0, '0);
  endtask

  // one random access or short well-formed sequence
  task automatic random_access;
    int r;
    logic [HART_W-1:0] h;
    logic [TIME_W-1:0] target;
    r = $urandom_range(0, 99);
    h = HART_W'($urandom_range(0, NUM_HARTS - 1));
    if (r < 35) begin
      send_access(OP_TICK, SEL_W'($urandom_range(0, 7)), HART_W'($urandom), $urandom);
    end else if (r < 55) begin
      send_access(OP_READ, SEL_W'($urandom_range(0, int'(SEL_TIME_HI))), h, $urandom);
    end else if (r < 65) begin
      send_access(OP_WRITE, SEL_SOFT, h, $urandom);
    end else if (r < 80) begin
      // arm a timer a few ticks around the current time
      target = mtime_m + 64'($urandom_range(0, 10)) - 64'd3;
      write_compare(h, target, 1'($urandom_range(0, 1)));
    end else if (r < 85) begin
      // bring the low word near its carry
      send_access(OP_WRITE, SEL_TIME_LO, h, 32'hFFFF_FFF8 + $urandom_range(0, 7));
    end else if (r < 88) begin
      write_compare(h, CMP_DISABLED, 1'($urandom_range(0, 1)));
    end else if (r < 92) begin
      send_access(OP_WRITE, SEL_W'($urandom_range(int'(SEL_CMP_LO), int'(SEL_CMP_HI))), h,
                  $urandom);
    end else if (r < 95) begin
      send_access(OP_WRITE, SEL_TIME_HI, h, ($urandom_range(0, 3) == 0) ? '1 : $urandom);
    end else begin
      send_access(OP_W'($urandom_range(0, 3)), SEL_W'($urandom_range(0, 7)),
                  HART_W'($urandom), $urandom);
    end
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure;
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    src_idle = 1'b0;
    repeat (24) random_access();
    drain();
  endtask

  // random traffic with idling modes switched every hundred random accesses
  task automatic test_random_traffic;
    int stop_at;
    int mode;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      mode = $urandom_range(0, 3);
      src_idle  = mode[0];
      sink_idle = mode[1];
      repeat (100) random_access();
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    error_count = 0;
    sent_count  = 0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    hold_req    = 1'b0;
    mtime_m     = '0;
    for (int i = 0; i < NUM_HARTS; i++) begin
      mtimecmp_m[i] = CMP_DISABLED;
      msip_m[i]     = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_soft_flags();
    test_timer();
    test_unused_codes();
    drain();
    test_backpressure();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (error_count == 0 && view_q.size() == 0) begin
      $display("core_local_interruptor regression: pass");
    end else begin
      $display("core_local_interruptor regression: fail");
    end
    $finish;
  end

endmodule
